### src/intel_hex_window_parser_unit_macros.svh
// Assertion macros for the Intel HEX window parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef INTEL_HEX_WINDOW_PARSER_UNIT_MACROS_SVH
`define INTEL_HEX_WINDOW_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define IHWP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihwp check failed");

// Next-cycle implication
`define IHWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihwp check failed");

`else

`define IHWP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IHWP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/ihwp_pkg.sv
// Shared types, codes and helper functions for the Intel HEX window parser.
// No dependencies; used by ihwp_record and intel_hex_window_parser_unit.
`default_nettype none

package ihwp_pkg;

   // Result kinds
   localparam logic [2:0] KIND_BYTE       = 3'd0;
   localparam logic [2:0] KIND_END        = 3'd1;
   localparam logic [2:0] KIND_TEXT_ENDED = 3'd2;
   localparam logic [2:0] KIND_UNKNOWN    = 3'd3;
   localparam logic [2:0] KIND_MALFORMED  = 3'd4;

   // Record types
   localparam logic [7:0] REC_DATA       = 8'h00;
   localparam logic [7:0] REC_EOF        = 8'h01;
   localparam logic [7:0] REC_EXT_LINEAR = 8'h04;

   // Delimiter characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Character position limits
   localparam int unsigned POS_W       = 10;
   localparam logic [9:0]  POS_MAX     = 10'd1023;
   localparam logic [9:0]  POS_HEADER  = 10'd8;
   localparam logic [9:0]  POS_EXT_END = 10'd11;
   localparam logic [9:0]  POS_EXT_LIM = 10'd12;

   // Register indexes
   localparam int unsigned CSR_IDX_W        = 1;
   localparam logic [0:0]  CSR_WINDOW_START = 1'b0;
   localparam logic [0:0]  CSR_WINDOW_END   = 1'b1;

   typedef struct packed {
      logic [7:0] in_char;
      logic       text_done;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] write_offset;
      logic [7:0]  write_byte;
      logic [31:0] first_addr;
      logic [31:0] last_addr;
      logic [31:0] byte_count;
   } rsp_type;

   // What the record parser reports for one character
   typedef struct packed {
      logic        emit_byte;
      logic [31:0] addr;
      logic [7:0]  data;
      logic        stop;
      logic [2:0]  kind;
   } event_type;

   // Decode an ASCII hex digit: {valid, value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         res = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         res = {1'b1, c[3:0] + 4'd9};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### src/ihwp_record.sv
// Record parser of the Intel HEX window parser: position, fields, address, stop flag.
// Depends on ihwp_pkg; reports one event_type per character to the top level.
`default_nettype none

module ihwp_record
   import ihwp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step,
   input  wire req_type   req,
   output event_type      evt
);

   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [15:0]      held_ff, held_in;
   logic [7:0]       len_ff,  len_in;
   logic [7:0]       type_ff, type_in;
   logic [31:0]      addr_ff, addr_in;
   logic             stopped_ff, stopped_in;

   logic [4:0]       nib;
   logic [15:0]      held_shift;
   logic [7:0]       type_shift;
   logic             is_delim;
   logic             needed;
   logic [10:0]      data_lim;

   // Decide whether the current position still belongs to a required field
   always_comb begin
      data_lim = 11'd8 + {2'b00, len_ff, 1'b0};
      needed   = 1'b0;
      if (pos_ff < POS_HEADER) begin
         needed = 1'b1;
      end else if (type_ff == REC_DATA) begin
         needed = ({1'b0, pos_ff} < data_lim);
      end else if (type_ff == REC_EXT_LINEAR) begin
         needed = (pos_ff < POS_EXT_LIM);
      end
   end

   // Work out the next state and the event for this character
   always_comb begin
      nib        = hex_nibble(req.in_char);
      held_shift = {held_ff[11:0], nib[3:0]};
      type_shift = {type_ff[3:0], nib[3:0]};
      is_delim   = (req.in_char == CHAR_COLON) || (req.in_char == CHAR_CR) ||
                   (req.in_char == CHAR_LF);

      pos_in  = pos_ff;
      held_in = held_ff;
      len_in  = len_ff;
      type_in = type_ff;
      addr_in = addr_ff;
      evt     = '0;

      if (!stopped_ff) begin
         if (req.text_done) begin
            evt.stop = 1'b1;
            evt.kind = (pos_ff != '0 && needed) ? KIND_MALFORMED : KIND_TEXT_ENDED;
         end else if (is_delim) begin
            if (pos_ff != '0) begin
               if (needed) begin
                  evt.stop = 1'b1;
                  evt.kind = KIND_MALFORMED;
               end else begin
                  pos_in  = '0;
                  held_in = '0;
                  len_in  = '0;
                  type_in = '0;
               end
            end
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 1'b1;
            end
            if (needed) begin
               if (!nib[4]) begin
                  evt.stop = 1'b1;
                  evt.kind = KIND_MALFORMED;
               end else if (pos_ff < 10'd2) begin
                  len_in = {len_ff[3:0], nib[3:0]};
               end else if (pos_ff < 10'd6) begin
                  held_in = held_shift;
               end else if (pos_ff < POS_HEADER) begin
                  type_in = type_shift;
                  // second type digit: act on the record type
                  if (pos_ff[0]) begin
                     case (type_shift)
                        REC_DATA:       addr_in = {addr_ff[31:16], held_ff};
                        REC_EXT_LINEAR: addr_in = addr_ff;
                        REC_EOF: begin
                           evt.stop = 1'b1;
                           evt.kind = KIND_END;
                        end
                        default: begin
                           evt.stop = 1'b1;
                           evt.kind = KIND_UNKNOWN;
                        end
                     endcase
                  end
               end else begin
                  held_in = held_shift;
                  if (type_ff == REC_DATA) begin
                     // odd position completes a data byte
                     if (pos_ff[0]) begin
                        evt.emit_byte = 1'b1;
                        evt.addr      = addr_ff;
                        evt.data      = held_shift[7:0];
                        addr_in       = addr_ff + 32'd1;
                     end
                  end else if (pos_ff == POS_EXT_END) begin
                     addr_in = {held_shift, addr_ff[15:0]};
                  end
               end
            end
         end
      end

      stopped_in = stopped_ff | evt.stop;
   end

   // Advance parser state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         held_ff    <= '0;
         len_ff     <= '0;
         type_ff    <= '0;
         addr_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (step) begin
         pos_ff     <= pos_in;
         held_ff    <= held_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         addr_ff    <= addr_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

`default_nettype wire

### src/intel_hex_window_parser_unit.sv
// Top level of the Intel HEX window parser: APB registers, window and statistics, output stage.
// Depends on ihwp_pkg, ihwp_record and intel_hex_window_parser_unit_macros.svh.
//
// The block takes one character of Intel HEX text per clock cycle and can accept a
// new transaction in every cycle while the result side keeps up. Each character is
// decoded by the record parser and the window and statistics logic in the same cycle
// it is accepted, and any result is registered in the output register, or in the skid
// register while the output register holds a result not yet taken. A two-entry output
// stage (output register plus skid register) lets input continue while one result waits;
// input stalls only when both entries are full. After an end record, an error or end of
// text the block swallows every further character without a result until reset.
`default_nettype none

`include "intel_hex_window_parser_unit_macros.svh"

module intel_hex_window_parser_unit
   import ihwp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   logic [31:0] win_start_ff, win_start_in;
   logic [31:0] win_end_ff,   win_end_in;
   logic [31:0] lowest_ff,    lowest_in;
   logic [31:0] highest_ff,   highest_in;
   logic [31:0] count_ff,     count_in;

   rsp_type     main_ff,  main_in;
   rsp_type     skid_ff,  skid_in;
   logic        main_valid_ff, main_valid_in;
   logic        skid_valid_ff, skid_valid_in;

   logic                 req_accept;
   logic                 rsp_pop;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;
   event_type            rec_evt;
   logic                 in_window;
   logic                 keep;
   logic                 push;
   rsp_type              new_rsp;

   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = rsp_valid && rsp_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   ihwp_record u_record (
      .clock (clock),
      .reset (reset),
      .step  (req_accept),
      .req   (req_data),
      .evt   (rec_evt)
   );

   // Window check and statistics for a decoded byte
   always_comb begin
      in_window = (rec_evt.addr >= win_start_ff) && (rec_evt.addr <= win_end_ff);
      keep      = req_accept && rec_evt.emit_byte && in_window;

      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      lowest_in    = lowest_ff;
      highest_in   = highest_ff;
      count_in     = count_ff;

      if (keep) begin
         if (rec_evt.addr < lowest_ff) begin
            lowest_in = rec_evt.addr;
         end
         if (rec_evt.addr > highest_ff) begin
            highest_in = rec_evt.addr;
         end
         if (count_ff != 32'hFFFF_FFFF) begin
            count_in = count_ff + 32'd1;
         end
      end

      // Register writes; reload the range while nothing is written yet
      if (csr_write) begin
         unique case (csr_idx)
            CSR_WINDOW_START: begin
               win_start_in = csr_pwdata;
               if (count_ff == '0) begin
                  highest_in = csr_pwdata;
               end
            end
            CSR_WINDOW_END: begin
               win_end_in = csr_pwdata;
               if (count_ff == '0) begin
                  lowest_in = csr_pwdata;
               end
            end
            default: begin
               win_start_in = win_start_ff;
            end
         endcase
      end
   end

   // Build the result transaction
   always_comb begin
      push                 = req_accept && (rec_evt.stop || keep);
      new_rsp.result_kind  = keep ? KIND_BYTE : rec_evt.kind;
      new_rsp.write_offset = keep ? (rec_evt.addr - win_start_ff) : 32'd0;
      new_rsp.write_byte   = keep ? rec_evt.data : 8'd0;
      new_rsp.first_addr   = lowest_in;
      new_rsp.last_addr    = highest_in;
      new_rsp.byte_count   = count_in;
   end

   // Output register with skid entry
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || rsp_pop) begin
         main_in       = new_rsp;
         main_valid_in = push;
      end else if (push) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   assign req_ready  = !skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_ff;
   assign csr_pready = 1'b1;

   // Register read-back
   always_comb begin
      unique case (csr_idx)
         CSR_WINDOW_START: csr_prdata = win_start_ff;
         CSR_WINDOW_END:   csr_prdata = win_end_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // Hold control and statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff  <= 32'd0;
         win_end_ff    <= 32'hFFFF_FFFF;
         lowest_ff     <= 32'hFFFF_FFFF;
         highest_ff    <= 32'd0;
         count_ff      <= 32'd0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         win_start_ff  <= win_start_in;
         win_end_ff    <= win_end_in;
         lowest_ff     <= lowest_in;
         highest_ff    <= highest_in;
         count_ff      <= count_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // Checks
   `IHWP_ASSERT_IMPL(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff)
   `IHWP_ASSERT_NEXT(a_stop_is_final, clock, reset, req_accept && rec_evt.stop, !rec_evt.stop && !rec_evt.emit_byte)
   `IHWP_ASSERT_IMPL(a_count_monotonic, clock, reset, !$past(reset), count_ff >= $past(count_ff))
   `IHWP_ASSERT_IMPL(a_range_ordered, clock, reset, count_ff != 32'd0, lowest_ff <= highest_ff)

endmodule

`default_nettype wire
